@@ sv/lfsa_pkg.sv @@
package lfsa_pkg;

    localparam int GATES   = 32;
    localparam int SLOT_AW = (GATES > 1) ? $clog2(GATES) : 1;
    localparam int SLOT_W  = 6;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 16;

    localparam logic [SLOT_W-1:0] GATES_MAX   = SLOT_W'(GATES);
    localparam logic [SLOT_W-1:0] GATES_RESET = 6'd32;
    localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};

    localparam logic KIND_GRANT = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_GRANT,
        ST_DUMP
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] end_time;
        logic [CNT_W-1:0]  served;
    } slot_entry_t;

    typedef struct packed {
        logic               we;
        logic [SLOT_AW-1:0] waddr;
        slot_entry_t        wdata;
        logic [SLOT_AW-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic              result_kind;
        logic [SLOT_W-1:0] slot_index;
        logic              granted;
        logic [CNT_W-1:0]  served_count;
        logic              last_of_run;
    } res_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

@@ sv/lfsa_ifs.sv @@
interface lfsa_req_if;
    import lfsa_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic              last_arrival;

    modport source (output valid, start_time, end_time, last_arrival, input ready);
    modport sink   (input valid, start_time, end_time, last_arrival, output ready);
endinterface

interface lfsa_res_if;
    import lfsa_pkg::*;
    logic              valid;
    logic              ready;
    logic              result_kind;
    logic [SLOT_W-1:0] slot_index;
    logic              granted;
    logic [CNT_W-1:0]  served_count;
    logic              last_of_run;

    modport source (output valid, result_kind, slot_index, granted, served_count,
                    last_of_run, input ready);
    modport sink   (input valid, result_kind, slot_index, granted, served_count,
                    last_of_run, output ready);
endinterface

interface lfsa_cfg_if;
    import lfsa_pkg::*;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] gates_in_use;

    modport source (output valid, gates_in_use, input ready);
    modport sink   (input valid, gates_in_use, output ready);
endinterface

@@ sv/lowest_free_slot_interval_allocator_core.sv @@
// Lowest-index free slot allocator: each request transfer (start_time, end_time) is
// granted the lowest slot in 1..G that is idle or whose stored end is strictly below
// start_time, where G is gates_in_use clipped to the slot count; one grant result
// (slot_index 0 and granted 0 when refused) follows each request. A request marked
// last_arrival additionally produces G+1 cumulative count entries for 0..G slots,
// saturating at 65535, after which all slots and counts clear. End times and served
// counts live in one synchronous slot RAM; busy flags sit in flip-flops and mask
// never-written RAM entries, so no clearing pass is needed after reset. After the
// request is taken, the scan reads one slot per cycle through the RAM port and
// stops once the free slot's data returns (or once all G slots are read), then the
// grant is posted. The count dump posts one entry per cycle while the result
// side keeps taking transfers. The next request is taken as soon as the previous
// one's results are posted, even while the last result still waits.
module lowest_free_slot_interval_allocator_core (
    input  logic      clk,
    input  logic      rst_n,
    lfsa_cfg_if.sink  cfg,
    lfsa_req_if.sink  req,
    lfsa_res_if.source res
);
    import lfsa_pkg::*;

    logic [SLOT_W-1:0] gates_reg;
    ram_req_t          ram_req;
    slot_entry_t       ram_rdata;
    logic              can_load;
    logic              load;
    res_t              res_data;

    // Accept configuration writes at any time; the host must write only while idle, which the block does not enforce.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gates_reg <= GATES_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            gates_reg <= cfg.gates_in_use;
        end
    end

    // Sequence scan, grant and dump; hold busy flags and the running sum.
    lfsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .gates     (gates_reg),
        .req       (req),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .can_load  (can_load),
        .load      (load),
        .res_data  (res_data)
    );

    // Store end time and served count per slot; one read, one write per cycle.
    lfsa_slot_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // Hold each result until the sink takes the transfer.
    lfsa_res_reg u_res (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .din      (res_data),
        .can_load (can_load),
        .res      (res)
    );

endmodule

@@ sv/lfsa_slot_ram.sv @@
module lfsa_slot_ram (
    input  logic                 clk,
    input  lfsa_pkg::ram_req_t   req,
    output lfsa_pkg::slot_entry_t rdata
);
    import lfsa_pkg::*;

    slot_entry_t entry_mem [GATES];
    slot_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            entry_mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= entry_mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/lfsa_res_reg.sv @@
module lfsa_res_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  lfsa_pkg::res_t din,
    output logic           can_load,
    lfsa_res_if.source     res
);
    import lfsa_pkg::*;

    logic valid_reg;
    res_t data_reg;

    // Slot is free when empty or when the held result transfers this cycle.
    assign can_load = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            data_reg <= din;
        end
    end

    assign res.valid        = valid_reg;
    assign res.result_kind  = data_reg.result_kind;
    assign res.slot_index   = data_reg.slot_index;
    assign res.granted      = data_reg.granted;
    assign res.served_count = data_reg.served_count;
    assign res.last_of_run  = data_reg.last_of_run;

endmodule

@@ sv/lfsa_ctrl.sv @@
module lfsa_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lfsa_pkg::SLOT_W-1:0] gates,
    lfsa_req_if.sink                    req,
    output lfsa_pkg::ram_req_t          ram_req,
    input  lfsa_pkg::slot_entry_t       ram_rdata,
    input  logic                        can_load,
    output logic                        load,
    output lfsa_pkg::res_t              res_data
);
    import lfsa_pkg::*;

    state_t              state_reg, state_next;
    logic [TIME_W-1:0]   start_reg;
    logic [TIME_W-1:0]   end_reg;
    logic                last_reg;
    logic [SLOT_W-1:0]   g_reg;
    logic [SLOT_W-1:0]   scan_idx_reg;
    logic                cmp_vld_reg;
    logic [SLOT_AW-1:0]  cmp_idx_reg;
    logic [SLOT_W-1:0]   chosen_reg;
    logic [GATES-1:0]    busy_reg;
    logic [SLOT_W-1:0]   dump_i_reg;
    logic [CNT_W-1:0]    sum_reg;

    logic                accept;
    logic                issue;
    logic                found;
    logic                none_free;
    logic [SLOT_W-1:0]   g_clip;
    logic [SLOT_W-1:0]   dump_prev;
    logic [CNT_W-1:0]    prev_served;
    logic [CNT_W-1:0]    dump_sum;
    logic                dump_end;

    assign g_clip    = (gates > GATES_MAX) ? GATES_MAX : gates;
    assign accept    = req.valid && req.ready;
    assign issue     = (scan_idx_reg < g_reg);
    assign found     = cmp_vld_reg &&
                       (!busy_reg[cmp_idx_reg] || (ram_rdata.end_time < start_reg));
    assign none_free = !cmp_vld_reg && !issue;

    assign dump_prev   = dump_i_reg - SLOT_W'(1);
    assign prev_served = busy_reg[dump_prev[SLOT_AW-1:0]] ? ram_rdata.served : '0;
    assign dump_sum    = (dump_i_reg == '0) ? '0 : sat_add(sum_reg, prev_served);
    assign dump_end    = (dump_i_reg == g_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (found || none_free)
                begin
                    state_next = ST_GRANT;
                end
            end
            ST_GRANT:
            begin
                if (can_load)
                begin
                    state_next = last_reg ? ST_DUMP : ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                if (can_load && dump_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready              = 1'b0;
        load                   = 1'b0;
        res_data               = '0;
        ram_req.we             = 1'b0;
        ram_req.waddr          = cmp_idx_reg;
        ram_req.wdata.end_time = end_reg;
        ram_req.wdata.served   = busy_reg[cmp_idx_reg] ? sat_inc(ram_rdata.served)
                                                       : CNT_W'(1);
        ram_req.raddr          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_SCAN:
            begin
                ram_req.raddr = scan_idx_reg[SLOT_AW-1:0];
                ram_req.we    = found;
            end
            ST_GRANT:
            begin
                load                  = can_load;
                res_data.result_kind  = KIND_GRANT;
                res_data.slot_index   = chosen_reg;
                res_data.granted      = (chosen_reg != '0);
                res_data.last_of_run  = !last_reg;
            end
            ST_DUMP:
            begin
                load                  = can_load;
                res_data.result_kind  = KIND_COUNT;
                res_data.slot_index   = dump_i_reg;
                res_data.served_count = dump_sum;
                res_data.last_of_run  = dump_end;
                // Fetch the slot for the next entry, or hold the current one.
                if (can_load)
                begin
                    ram_req.raddr = (dump_i_reg < GATES_MAX) ? dump_i_reg[SLOT_AW-1:0] : '0;
                end
                else
                begin
                    ram_req.raddr = dump_prev[SLOT_AW-1:0];
                end
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            busy_reg    <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    cmp_vld_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    cmp_vld_reg <= issue;
                    if (found)
                    begin
                        busy_reg[cmp_idx_reg] <= 1'b1;
                    end
                end
                ST_DUMP:
                begin
                    if (can_load && dump_end)
                    begin
                        busy_reg <= '0;
                    end
                end
                default:
                begin
                    cmp_vld_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    start_reg    <= req.start_time;
                    end_reg      <= req.end_time;
                    last_reg     <= req.last_arrival;
                    g_reg        <= g_clip;
                    scan_idx_reg <= '0;
                    chosen_reg   <= '0;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
                end
                cmp_idx_reg <= scan_idx_reg[SLOT_AW-1:0];
                if (found)
                begin
                    chosen_reg <= SLOT_W'(cmp_idx_reg) + SLOT_W'(1);
                end
            end
            ST_GRANT:
            begin
                dump_i_reg <= '0;
                sum_reg    <= '0;
            end
            ST_DUMP:
            begin
                if (can_load)
                begin
                    dump_i_reg <= dump_i_reg + SLOT_W'(1);
                    sum_reg    <= dump_sum;
                end
            end
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase
    end

endmodule

@@ sv/lfsa_checker.sv @@
module lfsa_assertions (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic                        result_kind,
    input logic [lfsa_pkg::SLOT_W-1:0] slot_index,
    input logic                        granted,
    input logic [lfsa_pkg::CNT_W-1:0]  served_count,
    input logic                        last_of_run
);
    import lfsa_pkg::*;

    // A grant names a slot exactly when it was granted.
    a_grant_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (result_kind == KIND_GRANT) |-> granted == (slot_index != '0))
        else $error("grant flag and slot index disagree");

    // Count entries never carry a grant flag; grants never carry a count.
    a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (result_kind == KIND_COUNT) ? !granted : (served_count == '0))
        else $error("fields inconsistent with result kind");

    // Slot zero never serves, so the first count entry is zero.
    a_zero_entry: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (result_kind == KIND_COUNT) && (slot_index == '0) |->
        served_count == '0)
        else $error("entry for zero slots is not zero");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(result_kind) &&
        $stable(slot_index) && $stable(granted) && $stable(served_count) &&
        $stable(last_of_run))
        else $error("stalled result changed");

endmodule

bind lowest_free_slot_interval_allocator_core lfsa_assertions u_lfsa_assertions (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .result_kind  (res.result_kind),
    .slot_index   (res.slot_index),
    .granted      (res.granted),
    .served_count (res.served_count),
    .last_of_run  (res.last_of_run)
);

@@ tb/lfsa_checker.sv @@
`timescale 1ns / 100ps

module lfsa_checker (
    input  logic clk,
    input  logic rst_n,
    lfsa_cfg_if  cfg,
    lfsa_req_if  req,
    lfsa_res_if  res,
    output int   mismatch_count,
    output int   pending_results
);
    import lfsa_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [SLOT_W-1:0] gate_limit;
    logic              slot_held [GATES];
    logic [TIME_W-1:0] slot_end  [GATES];
    logic [CNT_W-1:0]  slot_tally[GATES];
    res_t              awaited_results[$];
    int                errors = 0;

    task automatic clear_slots();
        int i;
        for (i = 0; i < GATES; i++)
        begin
            slot_held[i]  = 1'b0;
            slot_end[i]   = '0;
            slot_tally[i] = '0;
        end
    endtask

    // Grant the lowest qualifying slot; on the last request, also queue the running tallies.
    task automatic allocate_request(input logic [TIME_W-1:0] st,
                                    input logic [TIME_W-1:0] et,
                                    input logic              lst);
        int unsigned g;
        int unsigned pick;
        int unsigned sum;
        int unsigned i;
        res_t        r;
        g    = (gate_limit > GATES_MAX) ? GATES : int'(gate_limit);
        pick = 0;
        for (i = 1; i <= g; i++)
        begin
            if (pick == 0 && (!slot_held[i-1] || slot_end[i-1] < st))
                pick = i;
        end
        if (pick != 0)
        begin
            slot_held[pick-1] = 1'b1;
            slot_end[pick-1]  = et;
            if (slot_tally[pick-1] != CNT_MAX)
                slot_tally[pick-1] = slot_tally[pick-1] + CNT_W'(1);
        end
        r.result_kind  = KIND_GRANT;
        r.slot_index   = SLOT_W'(pick);
        r.granted      = (pick != 0);
        r.served_count = '0;
        r.last_of_run  = !lst;
        awaited_results.push_back(r);
        if (lst)
        begin
            sum = 0;
            for (i = 0; i <= g; i++)
            begin
                if (i > 0)
                begin
                    sum = sum + 32'(slot_tally[i-1]);
                    if (sum > CNT_MAX)
                        sum = 32'(CNT_MAX);
                end
                r.result_kind  = KIND_COUNT;
                r.slot_index   = SLOT_W'(i);
                r.granted      = 1'b0;
                r.served_count = CNT_W'(sum);
                r.last_of_run  = (i == g);
                awaited_results.push_back(r);
            end
            clear_slots();
        end
    endtask

    always @(posedge clk)
    begin : monitor
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            gate_limit = GATES_RESET;
            clear_slots();
            awaited_results.delete();
        end
        else
        begin
            // Compare first: a request taken at this edge cannot have produced this result.
            if (res.valid && res.ready)
            begin
                got.result_kind  = res.result_kind;
                got.slot_index   = res.slot_index;
                got.granted      = res.granted;
                got.served_count = res.served_count;
                got.last_of_run  = res.last_of_run;
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display({"%0t: unexpected result kind %0d slot %0d granted %0d ",
                                  "count %0d last %0d"},
                                 $realtime, got.result_kind, got.slot_index, got.granted,
                                 got.served_count, got.last_of_run);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display({"%0t: mismatch expected kind %0d slot %0d ",
                                      "granted %0d count %0d last %0d, got kind %0d ",
                                      "slot %0d granted %0d count %0d last %0d"},
                                     $realtime, want.result_kind, want.slot_index,
                                     want.granted, want.served_count, want.last_of_run,
                                     got.result_kind, got.slot_index, got.granted,
                                     got.served_count, got.last_of_run);
                    end
                end
            end
            if (cfg.valid && cfg.ready)
                gate_limit = cfg.gates_in_use;
            if (req.valid && req.ready)
                allocate_request(req.start_time, req.end_time, req.last_arrival);
        end
        mismatch_count  <= errors;
        pending_results <= awaited_results.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import lfsa_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 10;
    localparam int RANDOM_ITEMS    = 415;
    // a request scan plus a full count dump is well under this
    localparam int SETTLE_CYCLES   = 80;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int IDLE_LIMIT      = 3000;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   pending_results;
    int   idle_cycles;
    bit   steady_flow;
    bit   hold_off_req;

    lfsa_cfg_if cfg_ch ();
    lfsa_req_if req_ch ();
    lfsa_res_if res_ch ();

    lowest_free_slot_interval_allocator_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .res   (res_ch)
    );

    lfsa_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_ch),
        .req             (req_ch),
        .res             (res_ch),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(12, 60);
        return $urandom_range(1, 3);
    endfunction

    // Offer one request and hold it until the transfer; then maybe drop valid for a while.
    // With no gap, valid stays high so the caller's next request follows back to back.
    task automatic send_request(input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] et,
                                input logic lst);
        int gap;
        req_ch.valid        <= 1'b1;
        req_ch.start_time   <= st;
        req_ch.end_time     <= et;
        req_ch.last_arrival <= lst;
        do @(posedge clk); while (!req_ch.ready);
        gap = (steady_flow || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and hold the sender until every predicted result has been taken.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    // Write the slot count only with the block idle: drained, then given time to settle.
    task automatic write_gates(input logic [SLOT_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.gates_in_use <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drive every input to a known value from time zero, and release reset after a while.
    initial
    begin
        rst_n               <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.gates_in_use <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.start_time   <= '0;
        req_ch.end_time     <= '0;
        req_ch.last_arrival <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Result side: random stalls, one long hold-off on request, and stretches of steady flow.
    initial
    begin : result_side
        bit hold_done;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_off_req && !hold_done)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (steady_flow || $urandom_range(0, 3) != 0)
            begin
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run once nothing has been transferred for too long.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (cfg_ch.valid && cfg_ch.ready) || (req_ch.valid && req_ch.ready)
                || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("lowest_free_slot_interval_allocator_core verification failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [SLOT_W-1:0] gates;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] st;
        logic [TIME_W-1:0] et;
        logic              lst;
        int                span;
        int                run_len;
        int                phase;
        int                random_items;
        int                k;
        bit                noisy;

        steady_flow  = 1'b0;
        hold_off_req = 1'b0;
        while (!rst_n) @(posedge clk);
        @(posedge clk);

        // Reset value of 32 slots: back-to-back overlaps, a reused slot, an end equal to
        // the next start, the all-ones extreme, an unsorted start and an end before its start.
        send_request(32'd0, 32'd5, 1'b0);
        send_request(32'd3, 32'd10, 1'b0);
        send_request(32'd6, 32'd7, 1'b0);
        send_request(32'd7, 32'd7, 1'b0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_request(32'd0, 32'd0, 1'b0);
        send_request(32'd100, 32'd50, 1'b0);
        send_request(32'd200, 32'd300, 1'b1);

        // No slots at all: refused, and the dump holds only the zero-slot entry.
        write_gates(6'd0);
        send_request(32'd10, 32'd20, 1'b1);

        // One slot: grant, refusal, reuse with an end before its start, refusal on equal.
        write_gates(6'd1);
        send_request(32'd0, 32'd10, 1'b0);
        send_request(32'd5, 32'd20, 1'b0);
        send_request(32'd11, 32'd0, 1'b0);
        send_request(32'd0, 32'd3, 1'b1);

        // Above the slot count: acts as the full count.
        write_gates(6'd63);
        send_request(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        send_request(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);

        // Random phases: mostly sorted runs closed by a last request, some noise mixed in.
        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       gates = 6'd0;
                1:       gates = 6'd1;
                2:       gates = 6'd32;
                3:       gates = 6'd63;
                4:       gates = SLOT_W'($urandom_range(33, 62));
                default: gates = SLOT_W'($urandom_range(2, 31));
            endcase
            // Skipping the write now and then keeps the current count; a write without a
            // preceding last request changes the count in the middle of a run.
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_gates(gates);
            else
                drain_results();
            steady_flow = ($urandom_range(0, 4) == 0);
            run_len     = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 45)
                                                      : $urandom_range(1, 14);
            if (phase == 3)
            begin
                // Hold off the result side while requests keep coming, to back up the input.
                steady_flow  = 1'b0;
                hold_off_req = 1'b1;
                run_len      = 40;
            end
            noisy = ($urandom_range(0, 4) == 0);
            base  = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1000);
            span  = 1 << $urandom_range(1, 8);
            for (k = 0; k < run_len; k++)
            begin
                if (noisy && $urandom_range(0, 2) == 0)
                begin
                    st = $urandom();
                    et = $urandom();
                end
                else
                begin
                    base = base + $urandom_range(0, 6);
                    st   = base;
                    et   = base + $urandom_range(0, span);
                end
                lst = (k == run_len - 1) && ($urandom_range(0, 5) != 0);
                send_request(st, et, lst);
                random_items++;
            end
            phase++;
        end

        // Let the last results come, then watch for stray ones.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("lowest_free_slot_interval_allocator_core verification clean");
        else
            $display("lowest_free_slot_interval_allocator_core verification failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/lfsa_pkg.sv
sv/lfsa_ifs.sv
sv/lfsa_slot_ram.sv
sv/lfsa_res_reg.sv
sv/lfsa_ctrl.sv
sv/lowest_free_slot_interval_allocator_core.sv
sv/lfsa_checker.sv
tb/lfsa_checker.sv
tb/testbench.sv
